@@ src/b64e_pkg.sv @@
// Shared types, character constants and the symbol-to-character function of the Base64 encoder.
package b64e_pkg;

	localparam int unsigned CHAR_W = 7;
	localparam int unsigned SYM_W = 6;
	localparam int unsigned MAX_CHARS = 4;
	localparam int unsigned CNT_W = 3;

	localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 7'h30;
	localparam logic [CHAR_W-1:0] CH_PLUS = 7'h2B;
	localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;
	localparam logic [CHAR_W-1:0] CH_EQUALS = 7'h3D;
	localparam logic [CHAR_W-1:0] CH_STAR = 7'h2A;
	localparam logic [CHAR_W-1:0] CH_DASH = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 7'h5F;

	localparam logic [1:0] PHASE_FIRST = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD = 2'd2;

	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		char_t [MAX_CHARS-1:0] chars;
		logic [CNT_W-1:0]      count;
		logic                  last;
	} group_out_t;

	function automatic char_t sym_to_char(input logic [SYM_W-1:0] sym, input logic variant);
		char_t ch;
		ch = '0;
		priority if (sym < 6'd26) begin
			ch = CH_UPPER_A + {1'b0, sym};
		end else if (sym < 6'd52) begin
			ch = CH_LOWER_A + {1'b0, sym - 6'd26};
		end else if (sym < 6'd62) begin
			ch = CH_DIGIT_0 + {1'b0, sym - 6'd52};
		end else if (sym == 6'd62) begin
			ch = variant ? CH_STAR : CH_PLUS;
		end else begin
			ch = variant ? CH_DASH : CH_SLASH;
		end
		return ch;
	endfunction

	function automatic char_t pad_char(input logic variant);
		return variant ? CH_UNDERSCORE : CH_EQUALS;
	endfunction

endpackage

@@ src/base64_stream_encoder_top.sv @@
// Top level of the Base64 stream encoder: group state, character buffer and output register.
// A byte's characters pass through the character buffer and then the output register.
// The single output register gives one character per cycle while out_stall is low; a new byte
// is accepted only when the character buffer is empty or is popping its last character.
// Reset (arst_n low) clears the group position, leftover bits, buffer count, output valid and variant.
module base64_stream_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  out_char,
	output logic        last_char
);
	import b64e_pkg::*;

	logic                  variant_q;
	logic [1:0]            phase_q;
	logic [3:0]            carry_q;
	char_t [MAX_CHARS-1:0] buf_chars_s1;
	logic [CNT_W-1:0]      buf_cnt_q;
	logic                  buf_last_q;
	logic                  out_valid_q;
	char_t                 out_char_s2;
	logic                  out_last_s2;

	group_out_t            grp;
	logic [1:0]            next_phase;
	logic [3:0]            next_carry;
	logic                  pop;
	logic                  accept;

	b64e_split u_split (
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.phase      (phase_q),
		.carry      (carry_q),
		.variant    (variant_q),
		.result     (grp),
		.next_phase (next_phase),
		.next_carry (next_carry)
	);

	assign pop = (buf_cnt_q != '0) && (!out_valid_q || !out_stall);
	assign in_stall = !((buf_cnt_q == '0) || ((buf_cnt_q == CNT_W'(1)) && pop));
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (cfg_wr_en) begin
			variant_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_FIRST;
			carry_q <= '0;
		end else if (accept) begin
			phase_q <= next_phase;
			carry_q <= next_carry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
		end else if (accept) begin
			buf_cnt_q <= grp.count;
		end else if (pop) begin
			buf_cnt_q <= buf_cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_chars_s1 <= grp.chars;
			buf_last_q <= grp.last;
		end else if (pop) begin
			buf_chars_s1 <= {CHAR_W'(0), buf_chars_s1[MAX_CHARS-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_char_s2 <= buf_chars_s1[0];
			out_last_s2 <= buf_last_q && (buf_cnt_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_s2;
	assign last_char = out_last_s2;

endmodule

@@ src/b64e_split.sv @@
// Splits one byte into Base64 characters from the group position and the leftover bits.
module b64e_split (
	input  logic [7:0]              data_byte,
	input  logic                    last_byte,
	input  logic [1:0]              phase,
	input  logic [3:0]              carry,
	input  logic                    variant,
	output b64e_pkg::group_out_t    result,
	output logic [1:0]              next_phase,
	output logic [3:0]              next_carry
);
	import b64e_pkg::*;

	always_comb begin
		result = '0;
		result.last = last_byte;
		next_phase = PHASE_FIRST;
		next_carry = '0;
		unique case (phase)
			PHASE_SECOND: begin
				result.chars[0] = sym_to_char({carry[1:0], data_byte[7:4]}, variant);
				result.count = 3'd1;
				next_carry = data_byte[3:0];
				next_phase = PHASE_THIRD;
				if (last_byte) begin
					result.chars[1] = sym_to_char({data_byte[3:0], 2'b00}, variant);
					result.chars[2] = pad_char(variant);
					result.count = 3'd3;
				end
			end
			PHASE_THIRD: begin
				result.chars[0] = sym_to_char({carry, data_byte[7:6]}, variant);
				result.chars[1] = sym_to_char(data_byte[5:0], variant);
				result.count = 3'd2;
			end
			default: begin
				result.chars[0] = sym_to_char(data_byte[7:2], variant);
				result.count = 3'd1;
				next_carry = {2'b00, data_byte[1:0]};
				next_phase = PHASE_SECOND;
				if (last_byte) begin
					result.chars[1] = sym_to_char({data_byte[1:0], 4'b0000}, variant);
					result.chars[2] = pad_char(variant);
					result.chars[3] = pad_char(variant);
					result.count = 3'd4;
				end
			end
		endcase
		if (last_byte) begin
			next_phase = PHASE_FIRST;
			next_carry = '0;
		end
	end

endmodule
